### sv/pld3d_pkg.sv
// shared constants and item types for the point-to-line distance block
package pld3d_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIST_BITS   = 17;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
        logic signed [COORD_WIDTH-1:0] line_a_x;
        logic signed [COORD_WIDTH-1:0] line_a_y;
        logic signed [COORD_WIDTH-1:0] line_a_z;
        logic signed [COORD_WIDTH-1:0] line_b_x;
        logic signed [COORD_WIDTH-1:0] line_b_y;
        logic signed [COORD_WIDTH-1:0] line_b_z;
    } query_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic                 degenerate;
    } result_t;

endpackage

### sv/point_line_distance_3d_top.sv
// point-to-line distance pipeline: cross product, exact divide, integer square root
//
// query channel (query_valid/query_ready/query) takes a point P and two line
// points A, B; result channel (result_valid/result_ready/result) returns the
// floor of |(P-A)x(B-A)| / |B-A| and a degenerate flag (A equals B, distance 0).
// distances beyond the 17-bit range saturate to all ones.
// pipeline of 58 register stages:
//   7 arithmetic stages, 34 restoring divide stages (one quotient bit each),
//   17 square root stages (one root bit each)
// throughput: one item per cycle; every stage holds one item with a valid bit
// when result_valid is high and result_ready low, the whole pipeline holds
// and query_ready drops; nothing is lost or repeated
// reset clears all valid bits; the pipeline is empty and ready after reset
module point_line_distance_3d_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                query_valid,
    output logic                query_ready,
    input  pld3d_pkg::query_t   query,
    output logic                result_valid,
    input  logic                result_ready,
    output pld3d_pkg::result_t  result
);

    localparam int CW  = pld3d_pkg::COORD_WIDTH;
    localparam int DB  = pld3d_pkg::DIST_BITS;
    localparam int DW  = CW + 1;
    localparam int PW  = 2 * DW;
    localparam int MW  = PW;
    localparam int LW  = PW;
    localparam int SQW = 2 * MW;
    localparam int NW  = SQW + 2;
    localparam int QW  = 2 * DB;
    localparam int RW  = ((NW > LW + QW) ? NW : LW + QW) + 1;
    localparam int SW  = QW + 2;
    localparam int NS  = 7 + QW + DB;

    logic          adv;
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;

    assign adv          = !vld_reg[NS-1] || result_ready;
    assign query_ready  = adv;
    assign result_valid = vld_reg[NS-1];
    assign vld_next     = {vld_reg[NS-2:0], query_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: difference vectors
    logic signed [DW-1:0] vx_reg, vy_reg, vz_reg, dx_reg, dy_reg, dz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vx_reg <= DW'(query.point_x) - DW'(query.line_a_x);
            vy_reg <= DW'(query.point_y) - DW'(query.line_a_y);
            vz_reg <= DW'(query.point_z) - DW'(query.line_a_z);
            dx_reg <= DW'(query.line_b_x) - DW'(query.line_a_x);
            dy_reg <= DW'(query.line_b_y) - DW'(query.line_a_y);
            dz_reg <= DW'(query.line_b_z) - DW'(query.line_a_z);
        end
    end

    // stage 2: cross product terms and direction squares
    logic signed [PW-1:0] p1a_reg, p1b_reg, p2a_reg, p2b_reg, p3a_reg, p3b_reg;
    logic signed [PW-1:0] qx_reg, qy_reg, qz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1a_reg <= PW'(vy_reg) * PW'(dz_reg);
            p1b_reg <= PW'(vz_reg) * PW'(dy_reg);
            p2a_reg <= PW'(vz_reg) * PW'(dx_reg);
            p2b_reg <= PW'(vx_reg) * PW'(dz_reg);
            p3a_reg <= PW'(vx_reg) * PW'(dy_reg);
            p3b_reg <= PW'(vy_reg) * PW'(dx_reg);
            qx_reg  <= PW'(dx_reg) * PW'(dx_reg);
            qy_reg  <= PW'(dy_reg) * PW'(dy_reg);
            qz_reg  <= PW'(dz_reg) * PW'(dz_reg);
        end
    end

    // stage 3: cross magnitudes and squared length
    logic signed [PW:0] c1, c2, c3;
    logic [MW-1:0]      m1_reg, m2_reg, m3_reg;
    logic [LW-1:0]      len3_reg;

    assign c1 = (PW+1)'(p1a_reg) - (PW+1)'(p1b_reg);
    assign c2 = (PW+1)'(p2a_reg) - (PW+1)'(p2b_reg);
    assign c3 = (PW+1)'(p3a_reg) - (PW+1)'(p3b_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_reg   <= c1[PW] ? MW'(-c1) : MW'(c1);
            m2_reg   <= c2[PW] ? MW'(-c2) : MW'(c2);
            m3_reg   <= c3[PW] ? MW'(-c3) : MW'(c3);
            len3_reg <= LW'($unsigned(qx_reg)) + LW'($unsigned(qy_reg))
                        + LW'($unsigned(qz_reg));
        end
    end

    // stage 4: half-width partial products of the squares
    logic [PW-1:0] hh1_reg, hl1_reg, ll1_reg;
    logic [PW-1:0] hh2_reg, hl2_reg, ll2_reg;
    logic [PW-1:0] hh3_reg, hl3_reg, ll3_reg;
    logic [LW-1:0] len4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hh1_reg  <= PW'(m1_reg[MW-1:DW]) * PW'(m1_reg[MW-1:DW]);
            hl1_reg  <= PW'(m1_reg[MW-1:DW]) * PW'(m1_reg[DW-1:0]);
            ll1_reg  <= PW'(m1_reg[DW-1:0]) * PW'(m1_reg[DW-1:0]);
            hh2_reg  <= PW'(m2_reg[MW-1:DW]) * PW'(m2_reg[MW-1:DW]);
            hl2_reg  <= PW'(m2_reg[MW-1:DW]) * PW'(m2_reg[DW-1:0]);
            ll2_reg  <= PW'(m2_reg[DW-1:0]) * PW'(m2_reg[DW-1:0]);
            hh3_reg  <= PW'(m3_reg[MW-1:DW]) * PW'(m3_reg[MW-1:DW]);
            hl3_reg  <= PW'(m3_reg[MW-1:DW]) * PW'(m3_reg[DW-1:0]);
            ll3_reg  <= PW'(m3_reg[DW-1:0]) * PW'(m3_reg[DW-1:0]);
            len4_reg <= len3_reg;
        end
    end

    // stage 5: full squares
    logic [SQW-1:0] s1_reg, s2_reg, s3_reg;
    logic [LW-1:0]  len5_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg   <= (SQW'(hh1_reg) << (2 * DW)) + (SQW'(hl1_reg) << (DW + 1))
                        + SQW'(ll1_reg);
            s2_reg   <= (SQW'(hh2_reg) << (2 * DW)) + (SQW'(hl2_reg) << (DW + 1))
                        + SQW'(ll2_reg);
            s3_reg   <= (SQW'(hh3_reg) << (2 * DW)) + (SQW'(hl3_reg) << (DW + 1))
                        + SQW'(ll3_reg);
            len5_reg <= len4_reg;
        end
    end

    // stage 6: squared cross magnitude
    logic [NW-1:0] num6_reg;
    logic [LW-1:0] len6_reg;
    logic          deg6_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num6_reg <= NW'(s1_reg) + NW'(s2_reg) + NW'(s3_reg);
            len6_reg <= len5_reg;
            deg6_reg <= (len5_reg == '0);
        end
    end

    // stage 7 and divide stages: quotient of num by len, one bit per stage
    logic [RW-1:0] dv_rem_reg [0:QW];
    logic [QW-1:0] dv_q_reg   [0:QW];
    logic [LW-1:0] dv_len_reg [0:QW];
    logic          dv_deg_reg [0:QW];
    logic          dv_sat_reg [0:QW];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_rem_reg[0] <= RW'(num6_reg);
            dv_q_reg[0]   <= '0;
            dv_len_reg[0] <= len6_reg;
            dv_deg_reg[0] <= deg6_reg;
            dv_sat_reg[0] <= RW'(num6_reg) >= (RW'(len6_reg) << QW);
        end
    end

    genvar gj;
    generate
        for (gj = 1; gj <= QW; gj++)
        begin : g_div
            logic [RW-1:0] sh;
            logic          take;

            assign sh   = RW'(dv_len_reg[gj-1]) << (QW - gj);
            assign take = dv_rem_reg[gj-1] >= sh;

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_rem_reg[gj] <= take ? dv_rem_reg[gj-1] - sh : dv_rem_reg[gj-1];
                    dv_q_reg[gj]   <= dv_q_reg[gj-1] | (QW'(take) << (QW - gj));
                    dv_len_reg[gj] <= dv_len_reg[gj-1];
                    dv_deg_reg[gj] <= dv_deg_reg[gj-1];
                    dv_sat_reg[gj] <= dv_sat_reg[gj-1];
                end
            end
        end
    endgenerate

    // square root stages, one root bit per stage
    logic [SW-1:0] sq_rem_reg  [1:DB];
    logic [DB-1:0] sq_root_reg [1:DB];
    logic          sq_deg_reg  [1:DB];
    logic          sq_sat_reg  [1:DB];

    generate
        for (gj = 1; gj <= DB; gj++)
        begin : g_sqrt
            logic [SW-1:0] rem_in;
            logic [DB-1:0] root_in;
            logic          deg_in;
            logic          sat_in;
            logic [SW-1:0] cand;
            logic          take;

            if (gj == 1)
            begin : g_first
                assign rem_in  = SW'(dv_q_reg[QW]);
                assign root_in = '0;
                assign deg_in  = dv_deg_reg[QW];
                assign sat_in  = dv_sat_reg[QW];
            end
            else
            begin : g_next
                assign rem_in  = sq_rem_reg[gj-1];
                assign root_in = sq_root_reg[gj-1];
                assign deg_in  = sq_deg_reg[gj-1];
                assign sat_in  = sq_sat_reg[gj-1];
            end

            assign cand = (SW'(root_in) << (DB - gj + 1))
                          + (SW'(1) << (2 * (DB - gj)));
            assign take = rem_in >= cand;

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq_rem_reg[gj]  <= take ? rem_in - cand : rem_in;
                    sq_root_reg[gj] <= root_in | (DB'(take) << (DB - gj));
                    sq_deg_reg[gj]  <= deg_in;
                    sq_sat_reg[gj]  <= sat_in;
                end
            end
        end
    endgenerate

    always_comb
    begin
        result.degenerate = sq_deg_reg[DB];
        if (sq_deg_reg[DB])
        begin
            result.distance = '0;
        end
        else if (sq_sat_reg[DB])
        begin
            result.distance = '1;
        end
        else
        begin
            result.distance = sq_root_reg[DB];
        end
    end

endmodule
